// File: rtl/line_keyword_filter_unit_defines.svh
// Assertion macros shared by the line keyword filter RTL.
`ifndef LINE_KEYWORD_FILTER_UNIT_DEFINES_SVH
`define LINE_KEYWORD_FILTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define LKF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("line keyword filter check failed");
`define LKF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("line keyword filter check failed");
`else
`define LKF_ASSERT(lbl, clk, rst_n, prop)
`define LKF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/lkf_pkg.sv
// Shared types and constants of the line keyword filter.
package lkf_pkg;

    localparam int KEY_BYTES   = 8;
    localparam int WIN_W       = 8 * KEY_BYTES;
    localparam int KEY_W       = 64;
    localparam int KEY_LEN_W   = 4;
    localparam int OFS_W       = 32;
    localparam int CNT_W       = 40;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEYWORD_BYTES  = 1'b0,
        CFG_KEYWORD_LENGTH = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [KEY_W-1:0]     keyword;
        logic [KEY_LEN_W-1:0] eff_len;
    } t_cfg;

    typedef struct packed {
        logic [OFS_W-1:0] length;
        logic             hit;
    } t_line_stat;

    typedef struct packed {
        logic [OFS_W-1:0] line_start;
        logic [OFS_W-1:0] line_length;
        logic             line_matched;
        logic [CNT_W-1:0] total_lines;
        logic [CNT_W-1:0] matched_total;
    } t_result;

endpackage

// File: rtl/lkf_ifs.sv
// Channel interfaces of the line keyword filter: byte input, line result, config write.
interface lkf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_end;

    modport source (output valid, output data_byte, output chunk_end, input ready);
    modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface lkf_line_if import lkf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OFS_W-1:0] line_start;
    logic [OFS_W-1:0] line_length;
    logic             line_matched;
    logic [CNT_W-1:0] total_lines;
    logic [CNT_W-1:0] matched_total;

    modport source (output valid, output line_start, output line_length,
                    output line_matched, output total_lines, output matched_total,
                    input ready);
    modport sink (input valid, input line_start, input line_length,
                  input line_matched, input total_lines, input matched_total,
                  output ready);
endinterface

interface lkf_cfg_if import lkf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/lkf_cfg.sv
// Configuration registers: keyword bytes and clamped keyword length.
module lkf_cfg import lkf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lkf_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    logic [KEY_W-1:0]     r_keyword;
    logic [KEY_LEN_W-1:0] r_key_len;
    t_cfg_reg             wr_reg;

    assign i_cfg.ready = 1'b1;
    assign wr_reg      = t_cfg_reg'(i_cfg.index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyword <= '0;
            r_key_len <= '0;
        end else if (i_cfg.valid) begin
            unique case (wr_reg)
                CFG_KEYWORD_BYTES:  r_keyword <= i_cfg.data[KEY_W-1:0];
                CFG_KEYWORD_LENGTH: r_key_len <= i_cfg.data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.keyword = r_keyword;
    assign o_cfg.eff_len = (r_key_len > KEY_LEN_W'(KEY_BYTES)) ?
                           KEY_LEN_W'(KEY_BYTES) : r_key_len;

endmodule

// File: rtl/lkf_match.sv
// Current-line state: recent byte window, line length and keyword hit flag.
`include "line_keyword_filter_unit_defines.svh"
module lkf_match import lkf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_data_byte,
    input  logic       i_line_end,
    input  t_cfg       i_cfg,
    output t_line_stat o_stat
);

    logic [WIN_W-1:0]     r_window;
    logic [OFS_W-1:0]     r_len;
    logic                 r_hit;
    logic [WIN_W-1:0]     n_window;
    logic [OFS_W-1:0]     n_len;
    logic                 n_hit;
    logic                 is_newline;
    logic [KEY_BYTES-1:0] cmp;
    logic [KEY_BYTES-1:0] sel;
    logic                 hit_now;

    assign is_newline = (i_data_byte == NEWLINE_BYTE);

    genvar g;
    generate
        for (g = 1; g <= KEY_BYTES; g++) begin : g_cmp
            assign cmp[g-1] = (n_window[WIN_W-1 -: 8*g] == i_cfg.keyword[8*g-1:0]);
            assign sel[g-1] = (i_cfg.eff_len == KEY_LEN_W'(g));
        end
    endgenerate

    always_comb begin
        n_window = r_window;
        n_len    = r_len;
        if (!is_newline) begin
            n_window = {i_data_byte, r_window[WIN_W-1:8]};
            if (r_len != '1) begin
                n_len = r_len + OFS_W'(1);
            end
        end
    end

    assign hit_now = !is_newline && (n_len >= OFS_W'(i_cfg.eff_len)) && |(cmp & sel);
    assign n_hit   = r_hit || hit_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_len    <= '0;
            r_hit    <= 1'b0;
        end else if (i_advance) begin
            if (i_line_end) begin
                r_window <= '0;
                r_len    <= '0;
                r_hit    <= 1'b0;
            end else begin
                r_window <= n_window;
                r_len    <= n_len;
                r_hit    <= n_hit;
            end
        end
    end

    assign o_stat.length = n_len;
    assign o_stat.hit    = n_hit;

    `LKF_ASSERT(a_hit_needs_bytes, i_clk, i_rst_n, r_hit |-> (r_len != '0))
    `LKF_ASSERT(a_line_end_clears, i_clk, i_rst_n,
        (i_advance && i_line_end) |=> (r_len == '0 && !r_hit))

endmodule

// File: rtl/line_keyword_filter_unit.sv
// Line keyword filter top level: input register, line tracking, result register.
// Accepts one byte per clock cycle while the result register is not stalled. A
// byte is captured in the input register, its line state is updated there, and
// the result of a line that it ends is then loaded into the output register once
// that register is free or being read.
// The line window, offsets and totals are updated as a byte leaves the input
// register; a stalled result register holds the input register and, through it,
// the input channel. Configuration writes are always accepted and registered.
`include "line_keyword_filter_unit_defines.svh"
module line_keyword_filter_unit import lkf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkf_byte_if.sink    i_byte,
    lkf_cfg_if.sink     i_cfg,
    lkf_line_if.source  o_line
);

    t_cfg             cfg;
    t_line_stat       stat;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic [OFS_W-1:0] r_pos;
    logic [OFS_W-1:0] r_line_start;
    logic [CNT_W-1:0] r_line_count;
    logic [CNT_W-1:0] r_hit_count;
    logic             r_out_valid;
    t_result          r_out;

    logic             stage_go;
    logic             line_end;
    logic             emit;
    logic             matched;
    logic [OFS_W-1:0] pos_inc;
    logic [CNT_W-1:0] n_line_count;
    logic [CNT_W-1:0] n_hit_count;

    lkf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    lkf_match u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (stage_go),
        .i_data_byte (r_in_byte),
        .i_line_end  (line_end),
        .i_cfg       (cfg),
        .o_stat      (stat)
    );

    assign stage_go     = r_in_valid && (!r_out_valid || o_line.ready);
    assign i_byte.ready = !r_in_valid || stage_go;

    assign line_end = (r_in_byte == NEWLINE_BYTE) || r_in_last;
    assign emit     = line_end && (stat.length != '0);
    assign matched  = stat.hit || (cfg.eff_len == '0);
    assign pos_inc  = r_pos + OFS_W'(1);

    always_comb begin
        n_line_count = r_line_count;
        n_hit_count  = r_hit_count;
        if (emit) begin
            if (r_line_count != '1) begin
                n_line_count = r_line_count + CNT_W'(1);
            end
            if (matched && r_hit_count != '1) begin
                n_hit_count = r_hit_count + CNT_W'(1);
            end
        end
    end

    // hold the accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.chunk_end;
        end
    end

    // advance offsets and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_line_start <= '0;
            r_line_count <= '0;
            r_hit_count  <= '0;
        end else if (stage_go) begin
            r_pos        <= r_in_last ? '0 : pos_inc;
            if (line_end) begin
                r_line_start <= r_in_last ? '0 : pos_inc;
            end
            r_line_count <= n_line_count;
            r_hit_count  <= n_hit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_go) begin
            r_out_valid <= emit;
        end else if (o_line.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go && emit) begin
            r_out.line_start    <= r_line_start;
            r_out.line_length   <= stat.length;
            r_out.line_matched  <= matched;
            r_out.total_lines   <= n_line_count;
            r_out.matched_total <= n_hit_count;
        end
    end

    assign o_line.valid         = r_out_valid;
    assign o_line.line_start    = r_out.line_start;
    assign o_line.line_length   = r_out.line_length;
    assign o_line.line_matched  = r_out.line_matched;
    assign o_line.total_lines   = r_out.total_lines;
    assign o_line.matched_total = r_out.matched_total;

    `LKF_ASSERT(a_emit_loads_output, i_clk, i_rst_n, (stage_go && emit) |=> r_out_valid)
    `LKF_ASSERT(a_chunk_end_resets_pos, i_clk, i_rst_n,
        (stage_go && r_in_last) |=> (r_pos == '0 && r_line_start == '0))
    `LKF_ASSERT(a_hits_within_lines, i_clk, i_rst_n, r_hit_count <= r_line_count)
    `LKF_ASSERT(a_result_nonempty, i_clk, i_rst_n, r_out_valid |-> (r_out.line_length != '0))

endmodule
